[rtl/core/pffc_pkg.sv]
// Shared types, constants and helper functions for the prime-field Feistel cipher.
// It depends on nothing; every other file in rtl/core uses it.
package pffc_pkg;

	localparam int WORD_BITS  = 64;
	localparam int NUM_ROUNDS = 16;
	localparam int KEY_SLOTS  = 16;
	localparam int KEY_SLOT_W = $clog2(KEY_SLOTS);
	localparam int ROUND_W    = $clog2(NUM_ROUNDS);
	localparam int CNT_W      = $clog2(WORD_BITS);

	localparam logic [WORD_BITS-1:0] MODULUS_RESET = WORD_BITS'(64'hFFFF_FFFF_FFFF_FFC5);

	typedef logic [WORD_BITS-1:0] word_t;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_ENCRYPT = 2'd1,
		OP_DECRYPT = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	// (a + b) mod p for a, b below p
	function automatic word_t add_mod(input word_t a, input word_t b, input word_t p);
		logic [WORD_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, p})
			s = s - {1'b0, p};
		return s[WORD_BITS-1:0];
	endfunction

	// (a - b) mod p for a, b below p
	function automatic word_t sub_mod(input word_t a, input word_t b, input word_t p);
		word_t d;
		d = a - b;
		if (a < b)
			d = d + p;
		return d;
	endfunction

endpackage

[rtl/core/pffc_if.sv]
// Handshake channels of the prime-field Feistel cipher: request words and result words.
// It depends on pffc_pkg for the word width.
interface pffc_req_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      operation;
	logic [3:0]                      key_slot;
	logic [pffc_pkg::WORD_BITS-1:0]  key_word;
	logic [pffc_pkg::WORD_BITS-1:0]  block_high;
	logic [pffc_pkg::WORD_BITS-1:0]  block_low;

	modport source (output valid, operation, key_slot, key_word, block_high, block_low,
		input ready);
	modport sink (input valid, operation, key_slot, key_word, block_high, block_low,
		output ready);
endinterface

interface pffc_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [pffc_pkg::WORD_BITS-1:0]  result_high;
	logic [pffc_pkg::WORD_BITS-1:0]  result_low;

	modport source (output valid, result_high, result_low, input ready);
	modport sink (input valid, result_high, result_low, output ready);
endinterface

[rtl/core/prime_field_feistel_cipher_top.sv]
// Prime-field Feistel cipher: key store, sequencer and one shared shift-subtract divider.
// It depends on pffc_pkg and the channels in pffc_if.sv.
//
// A load word writes one of 16 round keys and gives no result. An encrypt or decrypt word
// is taken only while the block is idle and is worked on alone: both halves are reduced
// mod p, then each of the 16 rounds reduces its key and inverts the right half by extended
// Euclid. All of it runs through one shift-subtract divider that aligns the divisor one bit
// a cycle and then makes one quotient bit a cycle. A modulus below two gives zeros at once.
// The finished result sits in an output register until taken.
module prime_field_feistel_cipher_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [63:0]           cfg_wdata,
	pffc_req_if.sink              req,
	pffc_rsp_if.source            rsp
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_NORM = 8'b0000_0010,
		S_DIV  = 8'b0000_0100,
		S_EUC  = 8'b0000_1000,
		S_FIN  = 8'b0001_0000,
		S_FUNC = 8'b0010_0000,
		S_MIX  = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	typedef enum logic [1:0] {
		J_RED_L = 2'd0,
		J_RED_R = 2'd1,
		J_RED_K = 2'd2,
		J_INV   = 2'd3
	} job_t;

	state_t state_q;
	job_t   job_q;

	pffc_pkg::word_t modulus_q;
	pffc_pkg::word_t key_store [pffc_pkg::KEY_SLOTS];

	pffc_pkg::word_t rem_q, div_q, acc_q;
	pffc_pkg::word_t r0_q, r1_q, u0_q, u1_q;
	logic            n0_q, n1_q;
	logic [pffc_pkg::CNT_W-1:0] cnt_q;

	pffc_pkg::word_t left_q, right_q, key_q, inv_q, f_q;
	logic [pffc_pkg::ROUND_W-1:0] round_q;
	logic            decrypt_q;

	logic            out_valid_q;
	pffc_pkg::word_t out_high_q, out_low_q;

	// divider datapath
	logic                    rem_ge;
	pffc_pkg::word_t         rem_next, acc_next;
	logic [pffc_pkg::WORD_BITS:0] div_dbl;
	logic                    can_shift;

	logic [pffc_pkg::ROUND_W-1:0]    rnd_sel, slot_r;
	pffc_pkg::word_t                 key_rd;
	pffc_pkg::word_t                 inv_fin;
	logic                            req_fire;
	logic                            last_round;
	logic                            load_out;

	assign req.ready    = (state_q == S_IDLE);
	assign req_fire     = req.valid && req.ready;
	assign rsp.valid    = out_valid_q;
	assign rsp.result_high = out_high_q;
	assign rsp.result_low  = out_low_q;

	assign rem_ge   = (rem_q >= div_q);
	assign rem_next = rem_ge ? (rem_q - div_q) : rem_q;
	assign acc_next = {acc_q[pffc_pkg::WORD_BITS-2:0], 1'b0} + (rem_ge ? u1_q : '0);
	assign div_dbl  = {div_q, 1'b0};
	assign can_shift = !div_q[pffc_pkg::WORD_BITS-1] && (div_dbl <= {1'b0, rem_q});

	assign last_round = (round_q == pffc_pkg::ROUND_W'(pffc_pkg::NUM_ROUNDS - 1));
	assign rnd_sel    = (state_q == S_MIX) ? (round_q + 1'b1) : round_q;
	assign slot_r     = decrypt_q ? (pffc_pkg::ROUND_W'(pffc_pkg::NUM_ROUNDS - 1) - rnd_sel)
		: rnd_sel;
	assign key_rd     = key_store[pffc_pkg::KEY_SLOT_W'(slot_r)];

	// load the output register when it is free or being taken
	assign load_out   = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	always_comb begin
		inv_fin = '0;
		if (r0_q == pffc_pkg::WORD_BITS'(1)) begin
			if (n0_q)
				inv_fin = (u0_q == '0) ? '0 : (modulus_q - u0_q);
			else
				inv_fin = (u0_q >= modulus_q) ? (u0_q - modulus_q) : u0_q;
		end
	end

	// key store: no reset, written by load words
	always_ff @(posedge clk) begin
		if (req_fire && req.operation == pffc_pkg::OP_LOAD)
			key_store[req.key_slot] <= req.key_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			modulus_q <= pffc_pkg::MODULUS_RESET;
		else if (cfg_we)
			modulus_q <= cfg_wdata[pffc_pkg::WORD_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (rsp.valid && rsp.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			job_q       <= J_RED_L;
			round_q     <= '0;
			cnt_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_fire && (req.operation inside {pffc_pkg::OP_ENCRYPT,
						pffc_pkg::OP_DECRYPT})) begin
						decrypt_q <= (req.operation == pffc_pkg::OP_DECRYPT);
						round_q   <= '0;
						if (modulus_q < pffc_pkg::WORD_BITS'(2)) begin
							left_q  <= '0;
							right_q <= '0;
							state_q <= S_DONE;
						end else begin
							right_q <= req.block_low;
							rem_q   <= req.block_high;
							div_q   <= modulus_q;
							acc_q   <= '0;
							cnt_q   <= '0;
							job_q   <= J_RED_L;
							state_q <= S_NORM;
						end
					end
				end
				S_NORM: begin
					// align the divisor under the remainder
					if (can_shift) begin
						div_q <= div_dbl[pffc_pkg::WORD_BITS-1:0];
						cnt_q <= cnt_q + 1'b1;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= rem_next;
					acc_q <= acc_next;
					div_q <= div_q >> 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						case (job_q)
							J_RED_L: begin
								left_q  <= rem_next;
								rem_q   <= right_q;
								div_q   <= modulus_q;
								cnt_q   <= '0;
								job_q   <= J_RED_R;
								state_q <= S_NORM;
							end
							J_RED_R: begin
								right_q <= rem_next;
								rem_q   <= key_rd;
								div_q   <= modulus_q;
								cnt_q   <= '0;
								job_q   <= J_RED_K;
								state_q <= S_NORM;
							end
							J_RED_K: begin
								key_q <= rem_next;
								if (right_q == '0) begin
									inv_q   <= '0;
									state_q <= S_FUNC;
								end else begin
									r0_q    <= modulus_q;
									r1_q    <= right_q;
									u0_q    <= '0;
									u1_q    <= pffc_pkg::WORD_BITS'(1);
									n0_q    <= 1'b0;
									n1_q    <= 1'b0;
									rem_q   <= modulus_q;
									div_q   <= right_q;
									acc_q   <= '0;
									cnt_q   <= '0;
									job_q   <= J_INV;
									state_q <= S_NORM;
								end
							end
							default: state_q <= S_EUC;
						endcase
					end
				end
				S_EUC: begin
					// one Euclid step: shift remainders and coefficients down
					r0_q <= r1_q;
					r1_q <= rem_q;
					u0_q <= u1_q;
					u1_q <= u0_q + acc_q;
					n0_q <= n1_q;
					n1_q <= !n1_q;
					if (rem_q == '0) begin
						state_q <= S_FIN;
					end else begin
						div_q   <= rem_q;
						rem_q   <= r1_q;
						acc_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_NORM;
					end
				end
				S_FIN: begin
					inv_q   <= inv_fin;
					state_q <= S_FUNC;
				end
				S_FUNC: begin
					f_q     <= pffc_pkg::add_mod(inv_q, key_q, modulus_q);
					state_q <= S_MIX;
				end
				S_MIX: begin
					if (last_round) begin
						left_q  <= decrypt_q ? pffc_pkg::sub_mod(left_q, f_q, modulus_q)
							: pffc_pkg::add_mod(left_q, f_q, modulus_q);
						state_q <= S_DONE;
					end else begin
						// mix and swap halves, then fetch the next key
						right_q <= decrypt_q ? pffc_pkg::sub_mod(left_q, f_q, modulus_q)
							: pffc_pkg::add_mod(left_q, f_q, modulus_q);
						left_q  <= right_q;
						round_q <= round_q + 1'b1;
						rem_q   <= key_rd;
						div_q   <= modulus_q;
						acc_q   <= '0;
						cnt_q   <= '0;
						job_q   <= J_RED_K;
						state_q <= S_NORM;
					end
				end
				S_DONE: begin
					// hold until the output register is free
					if (load_out) begin
						out_high_q  <= left_q;
						out_low_q   <= right_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[verif/tb_prime_field_feistel_cipher_top.sv]
// Testbench for the prime-field Feistel cipher: directed and random words, checked
// against an in-bench cipher model. Depends on pffc_pkg and the channels in pffc_if.sv.
module tb_prime_field_feistel_cipher_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 6000000;
	localparam int SETTLE_CYCLES = 200;

	typedef struct packed {
		pffc_pkg::word_t hi;
		pffc_pkg::word_t lo;
	} halves_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [63:0] cfg_wdata = '0;
	int error_count = 0;
	int cycle_count = 0;
	int ready_hold = 0;
	int ready_run = 0;

	pffc_pkg::word_t field_p;
	pffc_pkg::word_t round_keys [pffc_pkg::KEY_SLOTS];
	halves_t pending_blocks [$];

	pffc_req_if req ();
	pffc_rsp_if rsp ();

	prime_field_feistel_cipher_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req(req.sink), .rsp(rsp.source)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	// result side: runs of steady ready broken by stalls
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			rsp.ready <= 1'b0;
		end else if (ready_run > 0) begin
			ready_run <= ready_run - 1;
			rsp.ready <= 1'b1;
		end else begin
			ready_hold <= pick_gap();
			ready_run <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 40);
			rsp.ready <= 1'b1;
		end
	end

	// extended Euclid; zero when no inverse exists
	function automatic pffc_pkg::word_t field_inverse(pffc_pkg::word_t a, pffc_pkg::word_t p);
		logic [pffc_pkg::WORD_BITS:0] r0, r1, q, t;
		logic signed [2*pffc_pkg::WORD_BITS+3:0] s0, s1, st;
		if (a == 0) return '0;
		r0 = {1'b0, p}; r1 = {1'b0, a}; s0 = 0; s1 = 1;
		while (r1 != 0) begin
			q = r0 / r1;
			t = r0 - q * r1; r0 = r1; r1 = t;
			st = s0 - $signed({1'b0, q}) * s1; s0 = s1; s1 = st;
		end
		if (r0 != 1) return '0;
		if (s0 < 0) s0 = s0 + $signed({1'b0, p});
		return s0[pffc_pkg::WORD_BITS-1:0];
	endfunction

	function automatic pffc_pkg::word_t fadd(pffc_pkg::word_t a, pffc_pkg::word_t b,
		pffc_pkg::word_t p);
		logic [pffc_pkg::WORD_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, p}) s = s - {1'b0, p};
		return s[pffc_pkg::WORD_BITS-1:0];
	endfunction

	function automatic halves_t feistel_cipher(pffc_pkg::op_t op, pffc_pkg::word_t hi,
		pffc_pkg::word_t lo);
		pffc_pkg::word_t left, right, f, k, t;
		int slot;
		halves_t res;
		if (field_p < 2) return '0;
		left = hi % field_p;
		right = lo % field_p;
		for (int r = 0; r < pffc_pkg::NUM_ROUNDS; r++) begin
			slot = (op == pffc_pkg::OP_ENCRYPT) ? r : pffc_pkg::NUM_ROUNDS - 1 - r;
			k = round_keys[slot % pffc_pkg::KEY_SLOTS] % field_p;
			f = fadd(field_inverse(right, field_p), k, field_p);
			if (op == pffc_pkg::OP_ENCRYPT)
				left = fadd(left, f, field_p);
			else
				left = (left >= f) ? left - f : left - f + field_p;
			if (r != pffc_pkg::NUM_ROUNDS - 1) begin
				t = left; left = right; right = t;
			end
		end
		res.hi = left;
		res.lo = right;
		return res;
	endfunction

	task automatic report(string what, pffc_pkg::word_t got, pffc_pkg::word_t want);
		error_count++;
		$display("MISMATCH %s: got %h expected %h", what, got, want);
	endtask

	// sampled at the falling edge so the word taken at the next rising edge is seen race-free
	always @(negedge clk) begin
		halves_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_blocks.size() == 0) begin
				report("unexpected result word", rsp.result_high, '0);
			end else begin
				want = pending_blocks.pop_front();
				if (rsp.result_high !== want.hi) report("result_high", rsp.result_high, want.hi);
				if (rsp.result_low !== want.lo) report("result_low", rsp.result_low, want.lo);
			end
		end
	end

	task automatic send_word(pffc_pkg::op_t op, logic [3:0] slot, pffc_pkg::word_t kw,
		pffc_pkg::word_t hi, pffc_pkg::word_t lo);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.operation <= op;
		req.key_slot <= slot;
		req.key_word <= kw;
		req.block_high <= hi;
		req.block_low <= lo;
		forever begin
			@(negedge clk);
			if (req.ready) break;
		end
		@(posedge clk);
		if (op == pffc_pkg::OP_LOAD)
			round_keys[slot] = kw;
		else if (op != pffc_pkg::OP_NONE)
			pending_blocks.push_back(feistel_cipher(op, hi, lo));
	endtask

	// hold the sender until every result is back and the block has settled
	task automatic drain();
		req.valid <= 1'b0;
		while (pending_blocks.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_modulus(pffc_pkg::word_t p);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= p;
		@(posedge clk);
		cfg_we <= 1'b0;
		field_p = p;
	endtask

	function automatic pffc_pkg::word_t pick_half();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return field_p - 1;
			3: return field_p;
			4: return pffc_pkg::word_t'($urandom_range(0, 5));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic test_key_loads();
		for (int s = 0; s < pffc_pkg::KEY_SLOTS; s++)
			send_word(pffc_pkg::OP_LOAD, s[3:0],
				(s == 0) ? '1 : (s == 1) ? '0 : {$urandom, $urandom},
				{$urandom, $urandom}, {$urandom, $urandom});
	endtask

	task automatic test_block_extremes();
		send_word(pffc_pkg::OP_ENCRYPT, 4'hF, '1, '0, '0);
		send_word(pffc_pkg::OP_DECRYPT, 4'h0, '0, '1, '1);
		send_word(pffc_pkg::OP_ENCRYPT, 4'h5, '0, field_p - 1, field_p);
		send_word(pffc_pkg::OP_NONE, 4'h3, '1, '1, '1);
		send_word(pffc_pkg::OP_DECRYPT, 4'hA, '1, field_p, field_p - 1);
		send_word(pffc_pkg::OP_ENCRYPT, 4'h0, '0, 64'd1, 64'd1);
	endtask

	task automatic test_degenerate_modulus();
		pffc_pkg::word_t mods [4] = '{64'd0, 64'd1, 64'd2, 64'd3};
		foreach (mods[i]) begin
			set_modulus(mods[i]);
			send_word(pffc_pkg::OP_ENCRYPT, 4'h0, '0, '1, 64'd2);
			send_word(pffc_pkg::OP_DECRYPT, 4'h0, '0, 64'd5, '0);
		end
	endtask

	task automatic test_random();
		pffc_pkg::word_t mods [6] = '{pffc_pkg::MODULUS_RESET, 64'd2305843009213693951,
			64'd65521, 64'd3, '1, 64'd4294967291};
		int r;
		foreach (mods[i]) begin
			set_modulus(mods[i]);
			for (int n = 0; n < 28; n++) begin
				r = $urandom_range(0, 19);
				if (r < 3)
					send_word(pffc_pkg::OP_LOAD, 4'($urandom),
						$urandom_range(0, 1) ? {$urandom, $urandom}
						: pffc_pkg::word_t'($urandom) % field_p, pick_half(), pick_half());
				else if (r == 3)
					send_word(pffc_pkg::OP_NONE, 4'($urandom), {$urandom, $urandom},
						pick_half(), pick_half());
				else
					send_word(r[0] ? pffc_pkg::OP_ENCRYPT : pffc_pkg::OP_DECRYPT,
						4'($urandom), {$urandom, $urandom}, pick_half(), pick_half());
			end
		end
	endtask

	initial begin
		req.valid <= 1'b0;
		req.operation <= pffc_pkg::OP_NONE;
		req.key_slot <= '0;
		req.key_word <= '0;
		req.block_high <= '0;
		req.block_low <= '0;
		field_p = pffc_pkg::MODULUS_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_key_loads();
		test_block_extremes();
		test_degenerate_modulus();
		test_random();
		drain();
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

[prime_field_feistel_cipher_top.f]
rtl/core/pffc_pkg.sv
rtl/core/pffc_if.sv
rtl/core/prime_field_feistel_cipher_top.sv
verif/tb_prime_field_feistel_cipher_top.sv
